// ===== hw/rtl/http_chunked_body_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// http chunked body decoder assertion macros
// immediate-style wrappers around concurrent properties, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, off during reset
`define HCBD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcbd assertion failed");
// next-cycle implication on clk, off during reset
`define HCBD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcbd assertion failed");
`else
`define HCBD_ASSERT_IMP(lbl, ante, cons)
`define HCBD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types, codes and helpers of the http chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;

	// result kinds
	typedef enum logic [1:0] {
		K_DATA  = 2'd0,
		K_OK    = 2'd1,
		K_TRUNC = 2'd2,
		K_NOHDR = 2'd3
	} kind_t;

	// decoder phase
	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SIZE   = 3'd1,
		PH_SKIP   = 3'd2,
		PH_DATA   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// one result word
	typedef struct packed {
		logic       run_last;
		logic       chunk_first;
		kind_t      kind;
		logic [7:0] out_byte;
	} res_t;

	// result queue geometry
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	// hex digit decode: bit 4 is valid, bits 3:0 the value
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/hcbd_core.sv =====
// ----------------------------------------------------------------------------
// hcbd_core
// decoder state registers and the per-byte update, up to two results a byte
// ----------------------------------------------------------------------------
module hcbd_core #(
	parameter int SIZE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic               final_byte,
	output hcbd_pkg::res_t     res0,
	output hcbd_pkg::res_t     res1,
	output logic [1:0]         res_num
);

	hcbd_pkg::phase_t     phase_q,  phase_n;
	logic [1:0]           hmc_q,    hmc_n;
	logic [SIZE_BITS-1:0] acc_q,    acc_n;
	logic                 de_q,     de_n;
	logic                 ds_q,     ds_n;
	logic [SIZE_BITS-1:0] br_q,     br_n;
	logic [1:0]           skip_q,   skip_n;
	logic                 fp_q,     fp_n;

	hcbd_pkg::kind_t      status;
	logic                 emit_data;
	logic                 emit_first;
	logic [7:0]           pat;
	logic [4:0]           hex;
	logic [SIZE_BITS-1:0] br_dec;
	logic [1:0]           skip_dec;

	always_comb begin
		phase_n    = phase_q;
		hmc_n      = hmc_q;
		acc_n      = acc_q;
		de_n       = de_q;
		ds_n       = ds_q;
		br_n       = br_q;
		skip_n     = skip_q;
		fp_n       = fp_q;
		status     = hcbd_pkg::K_OK;
		emit_data  = 1'b0;
		emit_first = 1'b0;
		pat        = hmc_q[0] ? hcbd_pkg::CHAR_LF : hcbd_pkg::CHAR_CR;
		hex        = hcbd_pkg::hex_decode(in_byte);
		br_dec     = (br_q != '0) ? br_q - SIZE_BITS'(1) : br_q;
		skip_dec   = (skip_q != 2'd0) ? skip_q - 2'd1 : skip_q;

		unique case (phase_q)
			hcbd_pkg::PH_HEADER: begin
				if (in_byte == pat) begin
					if (hmc_q == 2'd3) begin
						hmc_n   = 2'd0;
						phase_n = hcbd_pkg::PH_SIZE;
						acc_n   = '0;
						de_n    = 1'b0;
						ds_n    = 1'b0;
					end else begin
						hmc_n = hmc_q + 2'd1;
					end
				end else begin
					hmc_n = (in_byte == hcbd_pkg::CHAR_CR) ? 2'd1 : 2'd0;
				end
				if (phase_n == hcbd_pkg::PH_HEADER) status = hcbd_pkg::K_NOHDR;
			end
			hcbd_pkg::PH_SIZE: begin
				if (in_byte == hcbd_pkg::CHAR_CR) begin
					if (ds_q && acc_q != '0) begin
						br_n    = acc_q;
						skip_n  = 2'd1;
						phase_n = hcbd_pkg::PH_SKIP;
						status  = hcbd_pkg::K_TRUNC;
					end else begin
						phase_n = hcbd_pkg::PH_DONE;
					end
					acc_n = '0;
					de_n  = 1'b0;
					ds_n  = 1'b0;
				end else begin
					if (!de_q) begin
						if (!hex[4]) begin
							de_n = 1'b1;
						end else begin
							ds_n = 1'b1;
							// saturate once the top digit position is occupied
							if (acc_q[SIZE_BITS-1 -: 4] != 4'd0) begin
								acc_n = '1;
							end else begin
								acc_n = {acc_q[SIZE_BITS-5:0], hex[3:0]};
							end
						end
					end
					if (ds_n && acc_n != '0) status = hcbd_pkg::K_TRUNC;
				end
			end
			hcbd_pkg::PH_SKIP: begin
				skip_n = skip_dec;
				if (br_q != '0) status = hcbd_pkg::K_TRUNC;
				if (skip_dec == 2'd0) begin
					if (br_q != '0) begin
						phase_n = hcbd_pkg::PH_DATA;
						fp_n    = 1'b1;
					end else begin
						phase_n = hcbd_pkg::PH_SIZE;
						acc_n   = '0;
						de_n    = 1'b0;
						ds_n    = 1'b0;
					end
				end
			end
			hcbd_pkg::PH_DATA: begin
				emit_data  = 1'b1;
				emit_first = fp_q;
				fp_n       = 1'b0;
				br_n       = br_dec;
				if (br_dec == '0) begin
					phase_n = hcbd_pkg::PH_SKIP;
					skip_n  = 2'd2;
				end else begin
					status = hcbd_pkg::K_TRUNC;
				end
			end
			default: begin
				// end of body and unused codes: ignore bytes
			end
		endcase

		// final byte: back to reset state for the next response
		if (final_byte) begin
			phase_n = hcbd_pkg::PH_HEADER;
			hmc_n   = 2'd0;
			acc_n   = '0;
			de_n    = 1'b0;
			ds_n    = 1'b0;
			br_n    = '0;
			skip_n  = 2'd0;
			fp_n    = 1'b0;
		end
	end

	// result assembly
	always_comb begin
		res0 = '0;
		res1 = '0;
		if (emit_data) begin
			res0.out_byte    = in_byte;
			res0.kind        = hcbd_pkg::K_DATA;
			res0.chunk_first = emit_first;
			res0.run_last    = !final_byte;
			res1.kind        = status;
			res1.run_last    = 1'b1;
			res_num          = final_byte ? 2'd2 : 2'd1;
		end else begin
			res0.kind     = status;
			res0.run_last = 1'b1;
			res_num       = final_byte ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_HEADER;
			hmc_q   <= 2'd0;
			acc_q   <= '0;
			de_q    <= 1'b0;
			ds_q    <= 1'b0;
			br_q    <= '0;
			skip_q  <= 2'd0;
			fp_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			hmc_q   <= hmc_n;
			acc_q   <= acc_n;
			de_q    <= de_n;
			ds_q    <= ds_n;
			br_q    <= br_n;
			skip_q  <= skip_n;
			fp_q    <= fp_n;
		end
	end

endmodule

// ===== hw/rtl/hcbd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// hcbd_out_fifo
// small result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module hcbd_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  push_num,
	input  hcbd_pkg::res_t              push0,
	input  hcbd_pkg::res_t              push1,
	input  logic                        pop,
	output hcbd_pkg::res_t              head,
	output logic                        not_empty,
	output logic [hcbd_pkg::FIFO_AW:0]  count
);

	hcbd_pkg::res_t                 mem [hcbd_pkg::FIFO_DEPTH];
	logic [hcbd_pkg::FIFO_AW-1:0]   wr_q;
	logic [hcbd_pkg::FIFO_AW-1:0]   rd_q;
	logic [hcbd_pkg::FIFO_AW:0]     count_q;
	logic                           do_pop;

	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem[rd_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push_num != 2'd0) mem[wr_q] <= push0;
		if (push_num == 2'd2) mem[wr_q + hcbd_pkg::FIFO_AW'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + hcbd_pkg::FIFO_AW'(push_num);
			if (do_pop) rd_q <= rd_q + hcbd_pkg::FIFO_AW'(1);
			count_q <= count_q + (hcbd_pkg::FIFO_AW + 1)'(push_num)
				- (hcbd_pkg::FIFO_AW + 1)'(do_pop);
		end
	end

endmodule

// ===== hw/rtl/http_chunked_body_decoder_top.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// decodes an http/1.1 chunked response body from a raw byte stream
// ----------------------------------------------------------------------------
// usage
//   s_* takes the raw response, one byte per word; s_tlast marks the last
//   byte of the response. m_* gives result words: body bytes (kind data)
//   and, after the last input byte, one status word (ok, truncated chunk,
//   or header end not found). chunk_first flags the first byte of each
//   chunk so a consumer can drop a chunk that the status calls truncated.
//   m_tlast marks the last result word caused by one input byte.
// timing
//   a byte's result words enter the result queue when the byte is accepted
//   and are offered on m_* from its head. one byte is taken per cycle while
//   s_tready is high; a final byte inside chunk data causes two result words.
//   the rate is set by the four-entry result queue that parts the byte
//   decoder from the output; s_tready is high while two entries are free.
// reset
//   arst_n clears the decoder to header search and empties the queue.
// stall
//   while m_tready is low results wait in the queue; once fewer than two
//   entries are free s_tready drops and no byte is lost.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_top_macros.svh"

module http_chunked_body_decoder_top #(
	parameter int SIZE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // final_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser,   // [1:0] kind, [2] chunk_first
	output logic       m_tlast    // run_last
);

	// byte accept strobe
	logic                       s_accept;
	// decoder results for the current byte
	hcbd_pkg::res_t             res0;
	hcbd_pkg::res_t             res1;
	logic [1:0]                 res_num;
	// queue head and fill level
	hcbd_pkg::res_t             head;
	logic                       q_not_empty;
	logic [hcbd_pkg::FIFO_AW:0] q_count;

	// room for the worst case of two results per byte
	assign s_tready = (q_count <= (hcbd_pkg::FIFO_AW + 1)'(hcbd_pkg::FIFO_DEPTH - 2));
	assign s_accept = s_tvalid && s_tready;

	hcbd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_accept),
		.in_byte    (s_tdata),
		.final_byte (s_tlast),
		.res0       (res0),
		.res1       (res1),
		.res_num    (res_num)
	);

	hcbd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_num  (s_accept ? res_num : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.pop       (m_tready),
		.head      (head),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	// output side straight from the queue head
	assign m_tvalid = q_not_empty;
	assign m_tdata  = head.out_byte;
	assign m_tuser  = {head.chunk_first, head.kind};
	assign m_tlast  = head.run_last;

	// a byte is only taken with room for both of its results
	`HCBD_ASSERT_IMP(a_room_on_accept, s_accept,
		q_count <= (hcbd_pkg::FIFO_AW + 1)'(hcbd_pkg::FIFO_DEPTH - 2))
	// a status word always closes the run of its byte
	`HCBD_ASSERT_IMP(a_status_last, m_tvalid && head.kind != hcbd_pkg::K_DATA, m_tlast)
	// chunk start only flagged on data words
	`HCBD_ASSERT_IMP(a_first_on_data, m_tvalid && head.chunk_first,
		head.kind == hcbd_pkg::K_DATA)
	// a final byte always leaves a status word in the queue
	`HCBD_ASSERT_NXT(a_final_status, s_accept && s_tlast, q_not_empty)

endmodule
